// ===== hw/rtl/uer_pkg.sv =====
// Shared types, codes and constants for the ultrasonic echo ranger.
// No dependencies; every other file of the block imports this package.
package uer_pkg;

  localparam int CFG_W            = 16;
  localparam int TRIG_W           = 8;
  localparam int SINCE_W          = 17;
  localparam int DIST_W           = 19;
  localparam int CFG_IDX_W        = 4;
  localparam int COUNTER_BITS_DEF = 16;

  // 0.017 cm/us in Q8, scaled by 2^10
  localparam int                   DIST_MULT_W = 13;
  localparam logic [DIST_MULT_W-1:0] DIST_MULT = 13'd4456;
  localparam int                   DIST_SHIFT  = 10;

  localparam logic [CFG_W-1:0]  MIN_ECHO_RST      = 16'd116;
  localparam logic [CFG_W-1:0]  MAX_ECHO_RST      = 16'd23200;
  localparam logic [CFG_W-1:0]  TIMEOUT_EXTRA_RST = 16'd10000;
  localparam logic [TRIG_W-1:0] TRIGGER_WIDTH_RST = 8'd10;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_OK      = 2'd1,
    ST_RANGE   = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_ECHO      = 4'd0,
    REG_MAX_ECHO      = 4'd1,
    REG_TIMEOUT_EXTRA = 4'd2,
    REG_TRIGGER_WIDTH = 4'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0]  min_echo;
    logic [CFG_W-1:0]  max_echo;
    logic [CFG_W-1:0]  timeout_extra;
    logic [TRIG_W-1:0] trigger_width;
  } cfg_t;

  typedef struct packed {
    logic              trig_level;
    logic              done_res;
    status_t           status;
    logic [DIST_W-1:0] distance_q8;
  } result_t;

endpackage

// ===== hw/rtl/uer_if.sv =====
// Valid/ready channel interfaces of the ultrasonic echo ranger.
// Depends on uer_pkg for payload widths and types.
interface uer_in_if;
  logic valid;
  logic ready;
  logic echo_level;
  logic start_request;

  modport source (output valid, output echo_level, output start_request, input ready);
  modport sink   (input valid, input echo_level, input start_request, output ready);
endinterface

interface uer_out_if import uer_pkg::*;;
  logic              valid;
  logic              ready;
  logic              trig_level;
  logic              done_res;
  status_t           status;
  logic [DIST_W-1:0] distance_q8;

  modport source (output valid, output trig_level, output done_res, output status,
                  output distance_q8, input ready);
  modport sink   (input valid, input trig_level, input done_res, input status,
                  input distance_q8, output ready);
endinterface

interface uer_cfg_if import uer_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/uer_cfg_regs.sv =====
// Configuration register file of the ultrasonic echo ranger.
// Depends on uer_pkg and the uer_cfg_if interface.
module uer_cfg_regs import uer_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  uer_cfg_if.sink   cfg_ch,
  output cfg_t      cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_MIN_ECHO:      cfg_nxt.min_echo      = cfg_ch.data;
        REG_MAX_ECHO:      cfg_nxt.max_echo      = cfg_ch.data;
        REG_TIMEOUT_EXTRA: cfg_nxt.timeout_extra = cfg_ch.data;
        REG_TRIGGER_WIDTH: cfg_nxt.trigger_width = cfg_ch.data[TRIG_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_echo      <= MIN_ECHO_RST;
      cfg_r.max_echo      <= MAX_ECHO_RST;
      cfg_r.timeout_extra <= TIMEOUT_EXTRA_RST;
      cfg_r.trigger_width <= TRIGGER_WIDTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== hw/rtl/uer_fsm.sv =====
// Measurement sequencer: trigger, wait for echo, pulse width count, distance.
// Depends on uer_pkg; result is registered by the top level.
module uer_fsm import uer_pkg::*; #(
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    advance,
  input  logic    echo_level,
  input  logic    start_request,
  input  cfg_t    cfg,
  output result_t res
);

  localparam int CMP_W  = (COUNTER_BITS > CFG_W) ? COUNTER_BITS : CFG_W;
  localparam int PROD_W = CMP_W + DIST_MULT_W;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_TRIG = 4'b0010,
    PH_WAIT = 4'b0100,
    PH_MEAS = 4'b1000
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  logic [TRIG_W-1:0]       ticks_r, ticks_nxt;
  logic [SINCE_W-1:0]      since_r, since_nxt;
  logic [COUNTER_BITS-1:0] pulse_r, pulse_nxt;
  logic                    echo_prev_r;

  logic [TRIG_W-1:0]  tw;
  logic [TRIG_W-1:0]  ticks_inc;
  logic [SINCE_W-1:0] since_lim;
  logic [CMP_W-1:0]   pulse_ext;
  logic [PROD_W-1:0]  prod;
  logic               in_window;
  logic               finished;

  assign tw        = (cfg.trigger_width == '0) ? TRIG_W'(1) : cfg.trigger_width;
  assign ticks_inc = (ticks_r == '1) ? ticks_r : ticks_r + TRIG_W'(1);
  assign since_lim = SINCE_W'(cfg.max_echo) + SINCE_W'(cfg.timeout_extra);
  assign pulse_ext = CMP_W'(pulse_r);
  assign in_window = (pulse_ext >= CMP_W'(cfg.min_echo)) &&
                     (pulse_ext <= CMP_W'(cfg.max_echo));
  assign prod      = PROD_W'(pulse_ext) * PROD_W'(DIST_MULT);

  always_comb begin
    phase_nxt = phase_r;
    ticks_nxt = ticks_r;
    since_nxt = since_r;
    pulse_nxt = pulse_r;
    finished  = 1'b0;
    res       = '0;
    res.status = ST_NONE;
    case (phase_r)
      PH_IDLE: begin
        if (start_request) begin
          res.trig_level = 1'b1;
          ticks_nxt      = TRIG_W'(1);
          if (tw == TRIG_W'(1)) begin
            phase_nxt = PH_WAIT;
            since_nxt = '0;
          end else begin
            phase_nxt = PH_TRIG;
          end
        end
      end
      PH_TRIG: begin
        res.trig_level = 1'b1;
        ticks_nxt      = ticks_inc;
        if (ticks_inc >= tw) begin
          phase_nxt = PH_WAIT;
          since_nxt = '0;
        end
      end
      PH_WAIT, PH_MEAS: begin
        since_nxt = (since_r == '1) ? since_r : since_r + SINCE_W'(1);
        if (phase_r == PH_WAIT) begin
          if (echo_level && !echo_prev_r) begin
            phase_nxt = PH_MEAS;
            pulse_nxt = COUNTER_BITS'(1);
          end
        end else if (echo_level) begin
          pulse_nxt = (pulse_r == '1) ? pulse_r : pulse_r + COUNTER_BITS'(1);
        end else begin
          finished     = 1'b1;
          res.done_res = 1'b1;
          phase_nxt    = PH_IDLE;
          if (in_window) begin
            res.status      = ST_OK;
            res.distance_q8 = prod[DIST_SHIFT +: DIST_W];
          end else begin
            res.status = ST_RANGE;
          end
        end
        if (!finished && (since_nxt > since_lim)) begin
          res.done_res = 1'b1;
          res.status   = ST_TIMEOUT;
          phase_nxt    = PH_IDLE;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      ticks_r     <= '0;
      since_r     <= '0;
      pulse_r     <= '0;
      echo_prev_r <= 1'b0;
    end else if (advance) begin
      phase_r     <= phase_nxt;
      ticks_r     <= ticks_nxt;
      since_r     <= since_nxt;
      pulse_r     <= pulse_nxt;
      echo_prev_r <= echo_level;
    end
  end

endmodule

// ===== hw/rtl/ultrasonic_echo_ranger.sv =====
// Top level of the ultrasonic echo ranger: config registers, sequencer, result register.
// Depends on uer_pkg, the uer_*_if interfaces, uer_cfg_regs and uer_fsm.
//
// Usage:
//  in_ch carries one request per microsecond tick: echo_level and start_request.
//  out_ch returns exactly one result per request: trig_level, done_res, status,
//  distance_q8 (Q8 cm, nonzero only with status ok).
//  cfg_ch writes register index 0..3 (min echo, max echo, timeout extra,
//  trigger width); it is always ready and should be used only while idle.
//  A request's result is registered and appears on out_ch in the cycle after
//  it is accepted. Throughput is one request per cycle while out_ch does not
//  stall; the single result register sets this, and the sequencer state advances on each accepted request.
//  When out_ch stalls, the result holds in its register and in_ch.ready drops
//  until it is taken; a request is accepted in the cycle the result leaves.
//  Synchronous reset (rst_n low) returns the sequencer to idle, clears its
//  counters, clears the result valid flag and loads the register defaults.
module ultrasonic_echo_ranger import uer_pkg::*; #(
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  uer_in_if.sink     in_ch,
  uer_out_if.source  out_ch,
  uer_cfg_if.sink    cfg_ch
);

  cfg_t    cfg;
  result_t res;
  result_t out_res_r;
  logic    out_valid_r;
  logic    accept;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  uer_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  uer_fsm #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_fsm (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (accept),
    .echo_level    (in_ch.echo_level),
    .start_request (in_ch.start_request),
    .cfg           (cfg),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.trig_level  = out_res_r.trig_level;
  assign out_ch.done_res    = out_res_r.done_res;
  assign out_ch.status      = out_res_r.status;
  assign out_ch.distance_q8 = out_res_r.distance_q8;

  a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.done_res == (out_res_r.status != ST_NONE)))
    else $error("done_res and status disagree");

  a_dist_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.status != ST_OK) |-> (out_res_r.distance_q8 == '0))
    else $error("distance without ok status");

  a_trig_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.trig_level) |-> !out_res_r.done_res)
    else $error("trigger driven on a finishing tick");

  a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_valid_r && !out_ch.ready))
    else $error("input blocked without a stalled result");

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for ultrasonic_echo_ranger: a directed table, random ranging cycles, corner configs.
// Each result is compared with an in-bench model of the sequencer, or with a pinned table value.
// Depends on uer_pkg, the uer_*_if interfaces and the ranger RTL.
module testbench;
  import uer_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int unsigned CM_PER_US_SCALED = 4456;
  localparam int PRESSURE_AT = 150;
  localparam int PRESSURE_LEN = 40;

  typedef enum logic [1:0] {
    P_IDLE,
    P_TRIG,
    P_WAIT,
    P_MEAS
  } seq_phase_t;

  typedef struct {
    bit      echo;
    bit      start;
    bit      pinned;
    result_t want;
  } tick_row_t;

  localparam result_t R_QUIET   = '{1'b0, 1'b0, ST_NONE, '0};
  localparam result_t R_TRIG    = '{1'b1, 1'b0, ST_NONE, '0};
  localparam result_t R_TIMEOUT = '{1'b0, 1'b1, ST_TIMEOUT, '0};
  localparam result_t R_RANGE   = '{1'b0, 1'b1, ST_RANGE, '0};

  // run with min 1, max 3, extra 2, trigger width 0
  tick_row_t directed_ticks [22] = '{
    '{1'b0, 1'b0, 1'b1, R_QUIET},
    '{1'b1, 1'b1, 1'b1, R_TRIG},
    '{1'b1, 1'b0, 1'b0, R_QUIET},
    '{1'b0, 1'b0, 1'b0, R_QUIET},
    '{1'b1, 1'b1, 1'b0, R_QUIET},
    '{1'b1, 1'b0, 1'b0, R_QUIET},
    '{1'b1, 1'b0, 1'b0, R_QUIET},
    '{1'b0, 1'b0, 1'b0, R_QUIET},
    '{1'b0, 1'b1, 1'b1, R_TRIG},
    '{1'b0, 1'b0, 1'b0, R_QUIET},
    '{1'b0, 1'b0, 1'b0, R_QUIET},
    '{1'b0, 1'b0, 1'b0, R_QUIET},
    '{1'b0, 1'b0, 1'b0, R_QUIET},
    '{1'b0, 1'b0, 1'b0, R_QUIET},
    '{1'b0, 1'b0, 1'b1, R_TIMEOUT},
    '{1'b0, 1'b1, 1'b1, R_TRIG},
    '{1'b1, 1'b0, 1'b0, R_QUIET},
    '{1'b1, 1'b0, 1'b0, R_QUIET},
    '{1'b1, 1'b0, 1'b0, R_QUIET},
    '{1'b1, 1'b0, 1'b0, R_QUIET},
    '{1'b0, 1'b0, 1'b1, R_RANGE},
    '{1'b1, 1'b0, 1'b0, R_QUIET}
  };

  logic clk;
  logic rst_n;

  uer_in_if  in_ch();
  uer_out_if out_ch();
  uer_cfg_if cfg_ch();

  ultrasonic_echo_ranger dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // model state
  logic [CFG_W-1:0]            min_echo_us   = MIN_ECHO_RST;
  logic [CFG_W-1:0]            max_echo_us   = MAX_ECHO_RST;
  logic [CFG_W-1:0]            extra_us      = TIMEOUT_EXTRA_RST;
  logic [TRIG_W-1:0]           trig_width_us = TRIGGER_WIDTH_RST;
  seq_phase_t                  seq_phase     = P_IDLE;
  logic [TRIG_W-1:0]           trig_ticks    = '0;
  logic [SINCE_W-1:0]          since_trig    = '0;
  logic [COUNTER_BITS_DEF-1:0] pulse_us      = '0;
  logic                        echo_last     = 1'b0;

  result_t reading_q [$];
  result_t want_res;
  int      ticks_sent     = 0;
  int      finished_count = 0;
  int      results_seen   = 0;
  int      mismatches     = 0;
  int      cycle_count    = 0;
  int      stall_len;
  bit      burst          = 1'b0;
  bit      held_off       = 1'b0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic result_t ranger_tick(input logic echo, input logic start);
    result_t           r;
    logic [TRIG_W-1:0] tw;
    logic              closed;
    logic [31:0]       limit_us;
    r = '0;
    closed = 1'b0;
    tw = (trig_width_us == '0) ? TRIG_W'(1) : trig_width_us;
    limit_us = 32'(max_echo_us) + 32'(extra_us);
    case (seq_phase)
      P_IDLE: begin
        if (start) begin
          r.trig_level = 1'b1;
          trig_ticks = TRIG_W'(1);
          if (trig_ticks >= tw) begin
            seq_phase = P_WAIT;
            since_trig = '0;
          end else begin
            seq_phase = P_TRIG;
          end
        end
      end
      P_TRIG: begin
        r.trig_level = 1'b1;
        if (trig_ticks != '1) trig_ticks++;
        if (trig_ticks >= tw) begin
          seq_phase = P_WAIT;
          since_trig = '0;
        end
      end
      default: begin
        if (since_trig != '1) since_trig++;
        if (seq_phase == P_WAIT) begin
          if (echo && !echo_last) begin
            seq_phase = P_MEAS;
            pulse_us = COUNTER_BITS_DEF'(1);
          end
        end else if (echo) begin
          if (pulse_us != '1) pulse_us++;
        end else begin
          closed = 1'b1;
          r.done_res = 1'b1;
          if (pulse_us >= min_echo_us && pulse_us <= max_echo_us) begin
            r.status = ST_OK;
            r.distance_q8 = DIST_W'((32'(pulse_us) * CM_PER_US_SCALED) >> 10);
          end else begin
            r.status = ST_RANGE;
          end
          seq_phase = P_IDLE;
        end
        // falling edge beats timeout on the same tick
        if (!closed && 32'(since_trig) > limit_us) begin
          r.done_res = 1'b1;
          r.status = ST_TIMEOUT;
          seq_phase = P_IDLE;
        end
      end
    endcase
    echo_last = echo;
    if (r.done_res) finished_count++;
    return r;
  endfunction

  task automatic send_tick(input bit echo, input bit start, input bit pinned = 1'b0,
                           input result_t pinned_res = '0);
    int      gap;
    result_t r;
    gap = burst ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.echo_level <= echo;
    in_ch.start_request <= start;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = ranger_tick(echo, start);
    reading_q.push_back(pinned ? pinned_res : r);
    ticks_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (reading_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_MIN_ECHO:      min_echo_us = data;
      REG_MAX_ECHO:      max_echo_us = data;
      REG_TIMEOUT_EXTRA: extra_us = data;
      REG_TRIGGER_WIDTH: trig_width_us = data[TRIG_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic load_config(input int lo, input int hi, input int extra, input int trig);
    write_reg(REG_MIN_ECHO, CFG_W'(lo));
    write_reg(REG_MAX_ECHO, CFG_W'(hi));
    write_reg(REG_TIMEOUT_EXTRA, CFG_W'(extra));
    // upper byte is dropped by the register
    write_reg(REG_TRIGGER_WIDTH, {8'($urandom_range(0, 255)), 8'(trig)});
  endtask

  // one ranging cycle; pulse 0 drives no echo pulse, only noise when noisy is set
  task automatic measure(input int pulse, input bit noisy);
    int i;
    repeat (noisy ? $urandom_range(0, 3) : 0) send_tick(noisy & 1'($urandom_range(0, 1)), 1'b0);
    send_tick(noisy & 1'($urandom_range(0, 1)), 1'b1);
    while (seq_phase == P_TRIG)
      send_tick(noisy & 1'($urandom_range(0, 1)), noisy & 1'($urandom_range(0, 1)));
    repeat (noisy ? $urandom_range(0, 3) : 0)
      if (seq_phase == P_WAIT) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    if (pulse > 0) begin
      if (seq_phase == P_WAIT) send_tick(1'b0, noisy & 1'($urandom_range(0, 1)));
      if (seq_phase == P_WAIT) send_tick(1'b1, noisy & 1'($urandom_range(0, 1)));
      for (i = 1; i < pulse && seq_phase == P_MEAS; i++)
        send_tick(1'b1, noisy & 1'($urandom_range(0, 1)));
    end
    while (seq_phase != P_IDLE) send_tick(1'b0, noisy & 1'($urandom_range(0, 1)));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (reading_q.size() == 0) begin
        $error("result with no request pending");
        mismatches++;
      end else begin
        want_res = reading_q.pop_front();
        if (out_ch.trig_level !== want_res.trig_level) begin
          $error("trig_level: expected %0d, got %0d", want_res.trig_level, out_ch.trig_level);
          mismatches++;
        end
        if (out_ch.done_res !== want_res.done_res) begin
          $error("done_res: expected %0d, got %0d", want_res.done_res, out_ch.done_res);
          mismatches++;
        end
        if (out_ch.status !== want_res.status) begin
          $error("status: expected %0d, got %0d", want_res.status, out_ch.status);
          mismatches++;
        end
        if (out_ch.distance_q8 !== want_res.distance_q8) begin
          $error("distance_q8: expected %0d, got %0d", want_res.distance_q8,
                 out_ch.distance_q8);
          mismatches++;
        end
      end
    end
  end

  // result side: random stalls plus one long hold-off to back up the input
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!burst && !held_off && results_seen >= PRESSURE_AT) begin
        held_off = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (PRESSURE_LEN) @(negedge clk);
      end else if (!burst && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        stall_len = pick_gap();
        repeat (stall_len) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int lo;
    int hi;
    int w;
    int phase_no;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.echo_level = 1'b0;
    in_ch.start_request = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_MIN_ECHO;
    cfg_ch.data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    load_config(1, 3, 2, 0);
    foreach (directed_ticks[i])
      send_tick(directed_ticks[i].echo, directed_ticks[i].start, directed_ticks[i].pinned,
                directed_ticks[i].want);

    phase_no = 0;
    while (phase_no < 4 || ticks_sent < 300 || finished_count < 30) begin
      settle();
      lo = $urandom_range(0, 6);
      hi = ($urandom_range(0, 7) == 0) ? $urandom_range(0, lo) : lo + $urandom_range(0, 10);
      load_config(lo, hi, $urandom_range(0, 12),
                  ($urandom_range(0, 9) == 0) ? $urandom_range(6, 40) : $urandom_range(0, 5));
      burst = (phase_no == 2);
      repeat ($urandom_range(4, 8)) begin
        if ($urandom_range(0, 6) == 0) begin
          repeat ($urandom_range(5, 20))
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          while (seq_phase != P_IDLE) send_tick(1'b0, 1'b0);
        end else begin
          case ($urandom_range(0, 9))
            0:       w = 0;
            1, 2:    w = $urandom_range(1, lo + 1);
            3, 4:    w = hi + $urandom_range(1, 4);
            default: w = (lo <= hi) ? $urandom_range(lo, hi) : $urandom_range(1, hi + 2);
          endcase
          measure(w, 1'b1);
        end
      end
      burst = 1'b0;
      phase_no++;
    end

    // corner configurations, run without idling
    settle();
    burst = 1'b1;
    load_config(MIN_ECHO_RST, MAX_ECHO_RST, TIMEOUT_EXTRA_RST, TRIGGER_WIDTH_RST);
    measure(116, 1'b0);
    measure(20, 1'b0);
    settle();
    load_config(65535, 65535, 0, 1);
    measure(3, 1'b0);
    settle();
    load_config(0, 0, 0, 0);
    measure(2, 1'b0);
    settle();
    burst = 1'b0;

    repeat (4) @(posedge clk);
    if (mismatches == 0 && reading_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
